FILE: design/sha1h_pkg.sv
`default_nettype none
package sha1h_pkg;

    localparam int unsigned WordW     = 32;
    localparam int unsigned BlockW    = 512;
    localparam int unsigned NumChain  = 5;
    localparam int unsigned CountW    = 61;
    localparam int unsigned LenW      = 64;
    localparam int unsigned PosW      = 6;
    localparam int unsigned RoundW    = 7;
    localparam int unsigned IdxW      = 3;

    localparam logic [7:0]        PAD_BYTE      = 8'h80;
    localparam logic [PosW-1:0]   POS_LAST      = 6'h3F;
    localparam logic [PosW-1:0]   POS_LEN       = 6'd56;
    localparam logic [RoundW-1:0] ROUND_EXPAND  = 7'd16;
    localparam logic [RoundW-1:0] ROUND_PARITY1 = 7'd20;
    localparam logic [RoundW-1:0] ROUND_MAJ     = 7'd40;
    localparam logic [RoundW-1:0] ROUND_PARITY2 = 7'd60;
    localparam logic [RoundW-1:0] ROUND_LAST    = 7'd79;
    localparam logic [IdxW-1:0]   WORD_LAST     = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [WordW-1:0] digest_word;
        logic [IdxW-1:0]  word_index;
        logic             last_word;
    } out_item_t;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef enum logic [1:0] {
        FN_CHOOSE,
        FN_PARITY1,
        FN_MAJORITY,
        FN_PARITY2
    } round_fn_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LATCH,
        ST_PAD80,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic            byte_load;
        byte_src_t       byte_src;
        logic            count_inc;
        logic            len_load;
        logic            round_init;
        logic            round_en;
        logic            round_expand;
        round_fn_t       round_fn;
        logic            chain_add;
        logic            msg_clear;
        logic [IdxW-1:0] word_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_at_len;
    } dp_status_t;

    function automatic logic [WordW-1:0] chain_init(input logic [IdxW-1:0] idx);
        logic [WordW-1:0] v;
        unique case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hC3D2E1F0;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [WordW-1:0] round_k(input round_fn_t fn);
        logic [WordW-1:0] v;
        unique case (fn)
            FN_CHOOSE:   v = 32'h5A827999;
            FN_PARITY1:  v = 32'h6ED9EBA1;
            FN_MAJORITY: v = 32'h8F1BBCDC;
            FN_PARITY2:  v = 32'hCA62C1D6;
            default:     v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: design/sha1h_ctrl.sv
`default_nettype none
module sha1h_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire sha1h_pkg::in_item_t   in_data,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire sha1h_pkg::dp_status_t status,
    output      sha1h_pkg::dp_cmd_t    cmd
);
    import sha1h_pkg::*;

    ctrl_state_t       state_reg, state_next;
    ctrl_state_t       resume_reg, resume_next;
    logic [RoundW-1:0] round_reg, round_next;
    logic [IdxW-1:0]   idx_reg, idx_next;
    round_fn_t         fn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
            round_reg  <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
        end
    end

    always_comb
    begin
        priority if (round_reg < ROUND_PARITY1)
            fn = FN_CHOOSE;
        else if (round_reg < ROUND_MAJ)
            fn = FN_PARITY1;
        else if (round_reg < ROUND_PARITY2)
            fn = FN_MAJORITY;
        else
            fn = FN_PARITY2;
    end

    always_comb
    begin
        state_next   = state_reg;
        resume_next  = resume_reg;
        round_next   = round_reg;
        idx_next     = idx_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd          = '0;
        cmd.byte_src = SRC_DATA;
        cmd.round_fn = fn;
        cmd.word_sel = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.byte_present)
                    begin
                        cmd.byte_load = 1'b1;
                        cmd.count_inc = 1'b1;
                        if (status.pos_last)
                        begin
                            cmd.round_init = 1'b1;
                            state_next     = ST_ROUND;
                            resume_next    = in_data.end_of_message ? ST_LATCH : ST_IDLE;
                        end
                        else if (in_data.end_of_message)
                        begin
                            state_next = ST_LATCH;
                        end
                    end
                    else if (in_data.end_of_message)
                    begin
                        state_next = ST_LATCH;
                    end
                end
            end
            ST_LATCH:
            begin
                cmd.len_load = 1'b1;
                state_next   = ST_PAD80;
            end
            ST_PAD80:
            begin
                cmd.byte_load = 1'b1;
                cmd.byte_src  = SRC_PAD;
                state_next    = ST_PAD_ZERO;
                if (status.pos_last)
                begin
                    cmd.round_init = 1'b1;
                    state_next     = ST_ROUND;
                    resume_next    = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (status.pos_at_len)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    cmd.byte_load = 1'b1;
                    cmd.byte_src  = SRC_ZERO;
                    if (status.pos_last)
                    begin
                        cmd.round_init = 1'b1;
                        state_next     = ST_ROUND;
                        resume_next    = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                cmd.byte_load = 1'b1;
                cmd.byte_src  = SRC_LEN;
                if (status.pos_last)
                begin
                    cmd.round_init = 1'b1;
                    state_next     = ST_ROUND;
                    resume_next    = ST_EMIT;
                end
            end
            ST_ROUND:
            begin
                cmd.round_en     = 1'b1;
                cmd.round_expand = (round_reg >= ROUND_EXPAND);
                if (round_reg == ROUND_LAST)
                begin
                    round_next = '0;
                    state_next = ST_FOLD;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                end
            end
            ST_FOLD:
            begin
                cmd.chain_add = 1'b1;
                state_next    = resume_reg;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (idx_reg == WORD_LAST)
                    begin
                        idx_next      = '0;
                        cmd.msg_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/sha1h_datapath.sv
`default_nettype none
module sha1h_datapath
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [7:0]               data_byte,
    input  wire sha1h_pkg::dp_cmd_t       cmd,
    output      sha1h_pkg::dp_status_t    status,
    output      logic [sha1h_pkg::WordW-1:0] digest_word
);
    import sha1h_pkg::*;

    logic [BlockW-1:0] block_reg, block_next;
    logic [WordW-1:0]  chain_reg [NumChain];
    logic [WordW-1:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [CountW-1:0] count_reg;
    logic [LenW-1:0]   len_reg;
    logic [PosW-1:0]   pos_reg;

    logic [7:0]        byte_in;
    logic [WordW-1:0]  w0, w2, w8, w13, mix, x, f, tmp;

    assign w0  = block_reg[BlockW-1 -: WordW];
    assign w2  = block_reg[BlockW-1-2*WordW -: WordW];
    assign w8  = block_reg[BlockW-1-8*WordW -: WordW];
    assign w13 = block_reg[BlockW-1-13*WordW -: WordW];
    assign mix = w13 ^ w8 ^ w2 ^ w0;
    assign x   = cmd.round_expand ? {mix[WordW-2:0], mix[WordW-1]} : w0;

    always_comb
    begin
        unique case (cmd.byte_src)
            SRC_DATA: byte_in = data_byte;
            SRC_PAD:  byte_in = PAD_BYTE;
            SRC_ZERO: byte_in = 8'h00;
            SRC_LEN:  byte_in = len_reg[LenW-1 -: 8];
            default:  byte_in = 8'h00;
        endcase
    end

    always_comb
    begin
        unique case (cmd.round_fn)
            FN_CHOOSE:   f = (b_reg & c_reg) | (~b_reg & d_reg);
            FN_MAJORITY: f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default:     f = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    assign tmp = {a_reg[WordW-6:0], a_reg[WordW-1 -: 5]} + f + e_reg
                 + round_k(cmd.round_fn) + x;

    always_comb
    begin
        block_next = block_reg;
        if (cmd.byte_load)
            block_next = {block_reg[BlockW-9:0], byte_in};
        else if (cmd.round_en)
            block_next = {block_reg[BlockW-WordW-1:0], x};
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
        if (cmd.round_init)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.round_en)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[WordW-1:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.len_load)
            len_reg <= {count_reg, 3'b000};
        else if (cmd.byte_load && (cmd.byte_src == SRC_LEN))
            len_reg <= {len_reg[LenW-9:0], 8'h00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumChain; i++)
                chain_reg[i] <= chain_init(IdxW'(i));
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            if (cmd.msg_clear)
            begin
                for (int i = 0; i < NumChain; i++)
                    chain_reg[i] <= chain_init(IdxW'(i));
                count_reg <= '0;
            end
            else
            begin
                if (cmd.chain_add)
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                end
                if (cmd.count_inc)
                    count_reg <= count_reg + 1'b1;
            end
            if (cmd.byte_load)
                pos_reg <= pos_reg + 1'b1;
        end
    end

    assign status.pos_last   = (pos_reg == POS_LAST);
    assign status.pos_at_len = (pos_reg == POS_LEN);

    always_comb
    begin
        unique case (cmd.word_sel)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            3'd4:    digest_word = chain_reg[4];
            default: digest_word = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: design/sha1_hash_engine_top.sv
// SHA-1 engine, bytes in and digest words out. The transfer that completes
// a 64-byte block is followed by a busy period (80 rounds through the single
// round unit, then a fold into the chaining words) before the next byte is
// taken. End of message latches the length, then loads the padding and
// length bytes (9 to 72) one at a time, steps from the zero fill to the
// length bytes, and compresses each block that it fills, then the five digest
// words H0..H4 are offered one per cycle while out_ready allows. No input is
// taken while the digest is shown; after the last word the engine is back at
// the initial chaining values.
`default_nettype none
module sha1_hash_engine_top
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire sha1h_pkg::in_item_t  in_data,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      sha1h_pkg::out_item_t out_data
);
    import sha1h_pkg::*;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [WordW-1:0] digest_word;

    sha1h_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sha1h_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (in_data.data_byte),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word)
    );

    assign out_data.digest_word = digest_word;
    assign out_data.word_index  = cmd.word_sel;
    assign out_data.last_word   = (cmd.word_sel == WORD_LAST);

endmodule
`default_nettype wire

FILE: design/sha1h_checker.sv
`default_nettype none
module sha1h_checker
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire sha1h_pkg::in_item_t  in_data,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire sha1h_pkg::out_item_t out_data
);
    import sha1h_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("digest word dropped or changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while digest pending");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_word == (out_data.word_index == WORD_LAST)))
        else $error("last_word flag out of step with word_index");

    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_word |=>
            out_valid && (out_data.word_index == IdxW'($past(out_data.word_index) + 1'b1)))
        else $error("digest words out of order");

    a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_word |=> in_ready && !out_valid)
        else $error("engine not idle after final digest transfer");

endmodule

bind sha1_hash_engine_top sha1h_checker u_sha1h_checker (.*);
`default_nettype wire
